>>> rtl/core/bm3_pkg.sv
// ----------------------------------------------------------------------------
// bm3_pkg
// Shared types, sizes and constants of the 3x3 edge-aware box mean filter.
// ----------------------------------------------------------------------------
package bm3_pkg;

  // grid and sample sizes
  localparam int MAX_GRID  = 1024;
  localparam int COL_W     = $clog2(MAX_GRID);
  localparam int SIZE_W    = COL_W + 1;
  localparam int SAMPLE_W  = 16;
  localparam int POS_W     = 10;

  // neighborhood sum of up to nine samples
  localparam int SUM_W       = SAMPLE_W + 4;
  localparam int RECIP_SHIFT = SUM_W + 4;
  localparam int RECIP_W     = RECIP_SHIFT - 1;
  localparam int PROD_W      = SUM_W + RECIP_W;

  // rounded-up reciprocals, exact for every sum below 2**SUM_W
  localparam longint RECIP_ONE = longint'(1) << RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(RECIP_ONE / 4);
  localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'((RECIP_ONE + 5) / 6);
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'((RECIP_ONE + 8) / 9);

  // configuration register map
  localparam int REG_IDX_W = 1;
  localparam int PADDR_W   = REG_IDX_W + 2;
  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_GRID);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GRID_COLUMNS,
    REG_GRID_ROWS
  } reg_idx_t;

  // input item kinds
  typedef enum logic {
    ACT_SAMPLE,
    ACT_FLUSH
  } action_t;

  // neighbor count classes
  typedef enum logic [1:0] {
    DIV_BY_4,
    DIV_BY_6,
    DIV_BY_9
  } div_sel_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SUM,
    ST_MUL,
    ST_OUT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic shift;
    logic sum;
    logic mul;
    logic out_load;
  } bm3_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic draining;
    logic emit;
    logic out_full;
  } bm3_stat_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v < SIZE_MIN) begin
      r = SIZE_MIN;
    end else if (v > SIZE_RESET) begin
      r = SIZE_RESET;
    end
    return r;
  endfunction

  function automatic logic [RECIP_W-1:0] recip_of(input div_sel_t d);
    logic [RECIP_W-1:0] r;
    unique case (d)
      DIV_BY_4: r = RECIP_4;
      DIV_BY_6: r = RECIP_6;
      DIV_BY_9: r = RECIP_9;
      default:  r = RECIP_9;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/bm3_regs.sv
// ----------------------------------------------------------------------------
// bm3_regs
// APB register file holding the clamped grid size; any write restarts a frame.
// ----------------------------------------------------------------------------
module bm3_regs import bm3_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output logic [SIZE_W-1:0]  grid_cols,
  output logic [SIZE_W-1:0]  grid_rows,
  output logic               restart
);

  logic [SIZE_W-1:0] cols_r, cols_nxt;
  logic [SIZE_W-1:0] rows_r, rows_nxt;
  logic              wr_en;
  reg_idx_t          idx;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[PADDR_W-1:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign restart    = wr_en;
  assign grid_cols  = cols_r;
  assign grid_rows  = rows_r;

  // write decode
  always_comb begin
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    if (wr_en) begin
      unique case (idx)
        REG_GRID_COLUMNS: cols_nxt = clamp_size(cfg_pwdata[SIZE_W-1:0]);
        REG_GRID_ROWS:    rows_nxt = clamp_size(cfg_pwdata[SIZE_W-1:0]);
        default:          cols_nxt = cols_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= SIZE_RESET;
      rows_r <= SIZE_RESET;
    end else begin
      cols_r <= cols_nxt;
      rows_r <= rows_nxt;
    end
  end

  // read decode
  always_comb begin
    unique case (idx)
      REG_GRID_COLUMNS: cfg_prdata = 32'(cols_r);
      REG_GRID_ROWS:    cfg_prdata = 32'(rows_r);
      default:          cfg_prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/bm3_ctrl.sv
// ----------------------------------------------------------------------------
// bm3_ctrl
// Sequencer: accept, shift window, sum, scale by reciprocal, load output.
// ----------------------------------------------------------------------------
module bm3_ctrl import bm3_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_flush,
  output logic      in_tready,
  input  bm3_stat_t stat,
  output bm3_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   take;

  // a flush before the frame is complete is consumed with no effect
  assign take = in_tvalid & ~(in_flush & ~stat.draining);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (take) state_nxt = ST_SHIFT;
      ST_SHIFT: state_nxt = stat.emit ? ST_SUM : ST_IDLE;
      ST_SUM:   state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_OUT;
      ST_OUT:   if (!stat.out_full) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = take;
      end
      ST_SHIFT: cmd.shift    = 1'b1;
      ST_SUM:   cmd.sum      = 1'b1;
      ST_MUL:   cmd.mul      = 1'b1;
      ST_OUT:   cmd.out_load = ~stat.out_full;
      default:  cmd          = '0;
    endcase
  end

endmodule

>>> rtl/core/bm3_datapath.sv
// ----------------------------------------------------------------------------
// bm3_datapath
// Line stores, 3x3 window, raster counters, masked sum, divider and output
// register.
// ----------------------------------------------------------------------------
module bm3_datapath import bm3_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  bm3_cmd_t            cmd,
  output bm3_stat_t           stat,
  input  logic                restart,
  input  logic [SIZE_W-1:0]   grid_cols,
  input  logic [SIZE_W-1:0]   grid_rows,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [SAMPLE_W-1:0] out_height,
  output logic [POS_W-1:0]    out_row,
  output logic [POS_W-1:0]    out_col,
  output logic                out_last
);

  // line stores
  logic [SAMPLE_W-1:0] upper_mem  [MAX_GRID];
  logic [SAMPLE_W-1:0] middle_mem [MAX_GRID];
  logic [SAMPLE_W-1:0] upper_rd_r, middle_rd_r, sample_r;

  // window, k = row (0 upper), j = column (2 newest)
  logic [SAMPLE_W-1:0] win_r [3][3];

  // raster counters
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [SIZE_W-1:0] in_row_r, in_row_nxt;
  logic [POS_W-1:0]  pos_row_r, pos_row_nxt;
  logic [POS_W-1:0]  pos_col_r, pos_col_nxt;
  logic [SIZE_W-1:0] col_inc, prow_inc, pcol_inc;
  logic              emit, cell_top, cell_bot, cell_left, cell_right, cell_last;

  // per-cell registers
  logic                top_r, bot_r, left_r, right_r;
  logic [POS_W-1:0]    cell_row_r, cell_col_r;
  logic                cell_last_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  div_sel_t            div_sel_r, div_sel_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [2:0]          row_use, col_use;
  logic [1:0]          n_edges;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_height_r;
  logic [POS_W-1:0]    out_row_r, out_col_r;
  logic                out_last_r;

  assign stat.draining = in_row_r >= grid_rows;
  assign stat.emit     = emit;
  assign stat.out_full = out_valid_r & ~out_tready;

  assign emit = (in_row_r >= SIZE_W'(2)) ||
                ((in_row_r == SIZE_W'(1)) && (in_col_r != '0));

  // line store reads and writes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      upper_rd_r <= upper_mem[in_col_r];
    end
    if (cmd.shift) begin
      upper_mem[in_col_r] <= middle_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      middle_rd_r <= middle_mem[in_col_r];
      sample_r    <= stat.draining ? '0 : in_sample;
    end
    if (cmd.shift) begin
      middle_mem[in_col_r] <= sample_r;
    end
  end

  // window shift
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= upper_rd_r;
      win_r[1][2] <= middle_rd_r;
      win_r[2][2] <= sample_r;
    end
  end

  // cell position flags
  assign col_inc    = SIZE_W'(in_col_r) + SIZE_W'(1);
  assign prow_inc   = SIZE_W'(pos_row_r) + SIZE_W'(1);
  assign pcol_inc   = SIZE_W'(pos_col_r) + SIZE_W'(1);
  assign cell_top   = pos_row_r == '0;
  assign cell_bot   = prow_inc == grid_rows;
  assign cell_left  = pos_col_r == '0;
  assign cell_right = pcol_inc == grid_cols;
  assign cell_last  = cell_bot & cell_right;

  // counter advance
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    pos_row_nxt = pos_row_r;
    pos_col_nxt = pos_col_r;
    if (restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      pos_row_nxt = '0;
      pos_col_nxt = '0;
    end else if (cmd.shift) begin
      if (col_inc >= grid_cols) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + SIZE_W'(1);
      end else begin
        in_col_nxt = col_inc[COL_W-1:0];
      end
      if (emit) begin
        if (cell_last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          pos_row_nxt = '0;
          pos_col_nxt = '0;
        end else if (cell_right) begin
          pos_col_nxt = '0;
          pos_row_nxt = prow_inc[POS_W-1:0];
        end else begin
          pos_col_nxt = pcol_inc[POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      pos_row_r <= '0;
      pos_col_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      pos_row_r <= pos_row_nxt;
      pos_col_r <= pos_col_nxt;
    end
  end

  // capture the emitted cell
  always_ff @(posedge clk) begin
    if (cmd.shift && emit) begin
      top_r       <= cell_top;
      bot_r       <= cell_bot;
      left_r      <= cell_left;
      right_r     <= cell_right;
      cell_row_r  <= pos_row_r;
      cell_col_r  <= pos_col_r;
      cell_last_r <= cell_last;
    end
  end

  // masked neighborhood sum and neighbor count class
  assign row_use = {~bot_r, 1'b1, ~top_r};
  assign col_use = {~right_r, 1'b1, ~left_r};
  assign n_edges = 2'(top_r | bot_r) + 2'(left_r | right_r);

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        if (row_use[k] && col_use[j]) begin
          sum_nxt = sum_nxt + SUM_W'(win_r[k][j]);
        end
      end
    end
  end

  always_comb begin
    case (n_edges)
      2'd2:    div_sel_nxt = DIV_BY_4;
      2'd1:    div_sel_nxt = DIV_BY_6;
      default: div_sel_nxt = DIV_BY_9;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sum_r     <= sum_nxt;
      div_sel_r <= div_sel_nxt;
    end
  end

  // division as a multiply by the reciprocal
  assign prod_nxt = PROD_W'(sum_r) * PROD_W'(recip_of(div_sel_r));

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_height_r <= prod_r[RECIP_SHIFT +: SAMPLE_W];
      out_row_r    <= cell_row_r;
      out_col_r    <= cell_col_r;
      out_last_r   <= cell_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_height = out_height_r;
  assign out_row    = out_row_r;
  assign out_col    = out_col_r;
  assign out_last   = out_last_r;

  // input column stays inside the configured row
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    SIZE_W'(in_col_r) < grid_cols)
    else $error("input column beyond grid width");

  // output cell stays inside the grid
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (SIZE_W'(pos_row_r) < grid_rows) && (SIZE_W'(pos_col_r) < grid_cols))
    else $error("output position beyond grid");

  // last cell of the grid starts a new frame
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.shift && emit && cell_last) |=>
      (pos_row_r == '0) && (pos_col_r == '0) && (in_col_r == '0) && (in_row_r == '0))
    else $error("frame not restarted after last cell");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_tready))
    else $error("output register overwritten");

endmodule

>>> rtl/core/box_mean_3x3_edge_aware_core.sv
// ----------------------------------------------------------------------------
// box_mean_3x3_edge_aware_core
// Streaming 3x3 mean filter over a height grid with edge-aware divisors.
// ----------------------------------------------------------------------------
// Usage: set grid_columns (0x0) and grid_rows (0x4) over the APB port; the
// low 11 bits are clamped to 3..1024; any write restarts the frame. Feed height
// samples in raster order on the in_ stream (tuser = 0). Each cell comes out
// on the out_ stream as the truncated mean of its in-grid 3x3 neighbors,
// tagged with its row and column; tlast marks the final cell. Results lag the
// input by one row plus one cell, so after the last sample send
// grid_columns + 1 flush beats (tuser = 1) to drain them. A flush that comes
// before the frame is complete is consumed and ignored.
// Sequencing: the sequencer takes one beat at a time through line store read,
// window shift, sum, reciprocal multiply and output load, and the input is
// ready for the next beat only once it is back in idle. A sample that yields
// no result returns to idle after the window shift; an ignored flush never
// leaves idle.
// The next beat is taken while a result waits in the output register; a
// stalled receiver holds the sequencer only while a new result waits to load.
// Reset clears the counters and output valid and sets both sizes to 1024.
// ----------------------------------------------------------------------------
module box_mean_3x3_edge_aware_core import bm3_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [15:0]        in_tdata,    // [15:0] height_sample
  input  logic               in_tuser,    // [0] action
  // result stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [39:0]        out_tdata,   // [15:0] smoothed_height, [25:16] out_row,
                                          // [35:26] out_column, [39:36] zero
  output logic               out_tlast,   // frame_last
  // configuration
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  bm3_cmd_t            cmd;
  bm3_stat_t           stat;
  logic [SIZE_W-1:0]   grid_cols, grid_rows;
  logic                restart;
  logic [SAMPLE_W-1:0] out_height;
  logic [POS_W-1:0]    out_row, out_col;

  bm3_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .grid_cols   (grid_cols),
    .grid_rows   (grid_rows),
    .restart     (restart)
  );

  bm3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_flush  (in_tuser == ACT_FLUSH),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bm3_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .restart    (restart),
    .grid_cols  (grid_cols),
    .grid_rows  (grid_rows),
    .in_sample  (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_height (out_height),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_last   (out_tlast)
  );

  // result packing
  assign out_tdata = {4'b0000, out_col, out_row, out_height};

endmodule
